/* src/tcspq_pkg.sv */
// ----------------------------------------------------------------------------
// tcspq_pkg
// Shared constants, types and codes for the three-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcspq_pkg;

    localparam int CLASS_DEPTH = 128;
    localparam int ID_WIDTH    = 16;
    localparam int NUM_CLASSES = 3;

    localparam int PTR_W  = $clog2(CLASS_DEPTH);
    localparam int CNT_W  = $clog2(CLASS_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_CLASSES * CLASS_DEPTH);
    localparam int QSEL_W = $clog2(NUM_CLASSES);

    // Payload widths of the channels.
    localparam int ITEM_W   = 16;
    localparam int COUNT_W  = 8;
    localparam int TOTAL_W  = 32;
    localparam int STATUS_W = 3;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ITEM_W-1:0]   item_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [TOTAL_W-1:0]  total_t;
    typedef logic [1:0]          class_t;
    typedef logic [ID_WIDTH-1:0] id_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [QSEL_W-1:0]   qsel_t;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam class_t CLASS_INVALID = 2'd0;

    localparam status_t ST_PUSHED  = 3'd0;
    localparam status_t ST_SERVED  = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_INVALID = 3'd3;
    localparam status_t ST_EMPTY   = 3'd4;

endpackage

`default_nettype wire

/* src/tcspq_in_if.sv */
// ----------------------------------------------------------------------------
// tcspq_in_if
// Command channel: push or pop requests with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcspq_in_if;
    import tcspq_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    item_t  item_id;
    class_t priority_class;

    modport source (output valid, output cmd, output item_id, output priority_class,
                    input ready);
    modport sink   (input valid, input cmd, input item_id, input priority_class,
                    output ready);
endinterface

`default_nettype wire

/* src/tcspq_out_if.sv */
// ----------------------------------------------------------------------------
// tcspq_out_if
// Result channel: one result item per command, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcspq_out_if;
    import tcspq_pkg::*;

    logic    valid;
    logic    ready;
    logic    served_valid;
    item_t   served_id;
    status_t status;
    count_t  high_count;
    count_t  mid_count;
    count_t  low_count;
    total_t  served_total;

    modport source (output valid, output served_valid, output served_id, output status,
                    output high_count, output mid_count, output low_count,
                    output served_total, input ready);
    modport sink   (input valid, input served_valid, input served_id, input status,
                    input high_count, input mid_count, input low_count,
                    input served_total, output ready);
endinterface

`default_nettype wire

/* src/three_class_strict_priority_queue.sv */
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue
// Three circular FIFOs in one shared RAM, served in strict priority order.
// A push or an empty pop shows its result in the cycle after acceptance; a
// successful pop goes through the RAM read register, then the output register.
// One push or empty pop is taken per cycle while the result channel is not
// stalled; a successful pop holds the input off in S_READ while its RAM read
// lands, so the next command waits until that pop's result is loaded.
// Reset: pointers, occupancies and the served count clear; RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module three_class_strict_priority_queue (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcspq_in_if.sink   req,
    tcspq_out_if.source rsp
);
    import tcspq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg, state_next;

    ptr_t   head_reg [NUM_CLASSES];
    ptr_t   head_next[NUM_CLASSES];
    ptr_t   tail_reg [NUM_CLASSES];
    ptr_t   tail_next[NUM_CLASSES];
    cnt_t   occ_reg  [NUM_CLASSES];
    cnt_t   occ_next [NUM_CLASSES];
    total_t total_reg, total_next;

    logic    out_valid_reg, out_valid_next;
    logic    out_served_reg, out_served_next;
    item_t   out_id_reg, out_id_next;
    status_t out_status_reg, out_status_next;
    count_t  out_high_reg, out_high_next;
    count_t  out_mid_reg, out_mid_next;
    count_t  out_low_reg, out_low_next;
    total_t  out_total_reg, out_total_next;

    // Shared RAM: class q occupies addresses q*CLASS_DEPTH .. q*CLASS_DEPTH+DEPTH-1.
    id_t   mem [NUM_CLASSES*CLASS_DEPTH];
    id_t   rdata_reg;
    logic  wr_en, rd_en;
    addr_t waddr, raddr;
    id_t   wdata;

    logic  in_ready, accept, out_take, load_out;
    qsel_t push_q, pop_q;
    logic  pop_hit;

    function automatic ptr_t advance(ptr_t p);
        return (p == ptr_t'(CLASS_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    function automatic addr_t addr_of(qsel_t q, ptr_t p);
        return addr_t'(32'(q) * CLASS_DEPTH + 32'(p));
    endfunction

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept   = req.valid && in_ready;
    assign out_take = out_valid_reg && rsp.ready;
    assign push_q   = qsel_t'(req.priority_class - 2'd1);
    assign wdata    = id_t'(req.item_id);

    always_comb
    begin
        pop_hit = 1'b1;
        pop_q   = '0;
        priority if (occ_reg[0] != '0)
        begin
            pop_q = qsel_t'(0);
        end
        else if (occ_reg[1] != '0)
        begin
            pop_q = qsel_t'(1);
        end
        else if (occ_reg[2] != '0)
        begin
            pop_q = qsel_t'(2);
        end
        else
        begin
            pop_hit = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        total_next = total_reg;

        out_valid_next  = out_valid_reg;
        out_served_next = out_served_reg;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        out_high_next   = out_high_reg;
        out_mid_next    = out_mid_reg;
        out_low_next    = out_low_reg;
        out_total_next  = out_total_reg;

        wr_en    = 1'b0;
        rd_en    = 1'b0;
        waddr    = addr_of(push_q, tail_reg[push_q]);
        raddr    = addr_of(pop_q, head_reg[pop_q]);
        load_out = 1'b0;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        if (state_reg == S_READ)
        begin
            // Read data for the pop accepted last cycle is now available.
            state_next      = S_IDLE;
            load_out        = 1'b1;
            out_served_next = 1'b1;
            out_id_next     = item_t'(rdata_reg);
            out_status_next = ST_SERVED;
        end
        else if (accept)
        begin
            unique case (req.cmd)
                CMD_PUSH:
                begin
                    load_out        = 1'b1;
                    out_served_next = 1'b0;
                    out_id_next     = '0;
                    if (req.priority_class == CLASS_INVALID)
                    begin
                        out_status_next = ST_INVALID;
                    end
                    else if (occ_reg[push_q] >= cnt_t'(CLASS_DEPTH))
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        tail_next[push_q] = advance(tail_reg[push_q]);
                        occ_next[push_q]  = occ_reg[push_q] + cnt_t'(1);
                        out_status_next   = ST_PUSHED;
                    end
                end
                CMD_POP:
                begin
                    if (pop_hit)
                    begin
                        rd_en            = 1'b1;
                        head_next[pop_q] = advance(head_reg[pop_q]);
                        occ_next[pop_q]  = occ_reg[pop_q] - cnt_t'(1);
                        total_next       = total_reg + total_t'(1);
                        state_next       = S_READ;
                    end
                    else
                    begin
                        load_out        = 1'b1;
                        out_served_next = 1'b0;
                        out_id_next     = '0;
                        out_status_next = ST_EMPTY;
                    end
                end
            endcase
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_high_next  = count_t'(occ_next[0]);
            out_mid_next   = count_t'(occ_next[1]);
            out_low_next   = count_t'(occ_next[2]);
            out_total_next = total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                occ_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_served_reg <= out_served_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
        out_high_reg   <= out_high_next;
        out_mid_reg    <= out_mid_next;
        out_low_reg    <= out_low_next;
        out_total_reg  <= out_total_next;
    end

    assign req.ready        = in_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.served_valid = out_served_reg;
    assign rsp.served_id    = out_id_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.high_count   = out_high_reg;
    assign rsp.mid_count    = out_mid_reg;
    assign rsp.low_count    = out_low_reg;
    assign rsp.served_total = out_total_reg;

    // A pending RAM read always lands in the output register on the next cycle.
    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> out_valid_reg)
        else $error("pop read did not produce a result");

    // No FIFO ever holds more entries than its depth.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg[0] <= cnt_t'(CLASS_DEPTH)) && (occ_reg[1] <= cnt_t'(CLASS_DEPTH))
        && (occ_reg[2] <= cnt_t'(CLASS_DEPTH)))
        else $error("FIFO occupancy exceeds depth");

    // A successful pop bumps the served count by exactly one.
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_POP) && pop_hit)
        |=> (total_reg == $past(total_reg) + total_t'(1)))
        else $error("served count did not advance on pop");

    // A waiting result always carries the current served count.
    a_total_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_total_reg == total_reg))
        else $error("result served count out of step");

    // A served result is flagged as such.
    a_served_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_served_reg == (out_status_reg == ST_SERVED)))
        else $error("served flag disagrees with status");

endmodule

`default_nettype wire
